// ===== hdl/mips1_integer_execute_unit_macros.svh =====
// ----------------------------------------------------------------------------
// MIPS-I execute unit assertion macros
// Shared assertion helpers for the execute unit; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MIPS1_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define MIPS1_INTEGER_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication.
`define MIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS-I execute unit package
// Operation codes and the decoded request record passed from front to back.
// ----------------------------------------------------------------------------
package mie_pkg;

  typedef enum logic [5:0] {
    OP_NOP, OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV, OP_JR, OP_JALR,
    OP_SYSCALL, OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_MULT, OP_MULTU, OP_DIV,
    OP_DIVU, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU,
    OP_BLTZ, OP_BGEZ, OP_BLTZAL, OP_BGEZAL, OP_J, OP_JAL, OP_BEQ, OP_BNE,
    OP_BLEZ, OP_BGTZ, OP_ADDI, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
    OP_LUI, OP_BAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  wreg;
    logic [31:0] word;
    logic [31:0] pc;
  } dec_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== hdl/mie_front.sv =====
// ----------------------------------------------------------------------------
// MIPS-I execute unit front end
// Accepts instruction requests, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module mie_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    instr_word,
  input  logic [31:0]    fetch_pc,
  output logic           push,
  input  logic           push_ready,
  output mie_pkg::dec_t  push_data
);
  import mie_pkg::*;

  localparam logic [5:0] PRI_SPECIAL = 6'h00, PRI_REGIMM = 6'h01, PRI_J = 6'h02,
    PRI_JAL = 6'h03, PRI_BEQ = 6'h04, PRI_BNE = 6'h05, PRI_BLEZ = 6'h06,
    PRI_BGTZ = 6'h07, PRI_ADDI = 6'h08, PRI_ADDIU = 6'h09, PRI_SLTI = 6'h0A,
    PRI_SLTIU = 6'h0B, PRI_ANDI = 6'h0C, PRI_ORI = 6'h0D, PRI_XORI = 6'h0E,
    PRI_LUI = 6'h0F;
  localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03,
    FN_SLLV = 6'h04, FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08,
    FN_JALR = 6'h09, FN_SYSCALL = 6'h0C, FN_MFHI = 6'h10, FN_MTHI = 6'h11,
    FN_MFLO = 6'h12, FN_MTLO = 6'h13, FN_MULT = 6'h18, FN_MULTU = 6'h19,
    FN_DIV = 6'h1A, FN_DIVU = 6'h1B, FN_ADD = 6'h20, FN_ADDU = 6'h21,
    FN_SUB = 6'h22, FN_SUBU = 6'h23, FN_AND = 6'h24, FN_OR = 6'h25,
    FN_XOR = 6'h26, FN_NOR = 6'h27, FN_SLT = 6'h2A, FN_SLTU = 6'h2B;
  localparam logic [4:0] RI_BLTZ = 5'h00, RI_BGEZ = 5'h01, RI_BLTZAL = 5'h10,
    RI_BGEZAL = 5'h11;
  localparam logic [4:0] LINK_REG = 5'd31;

  dec_t ent;
  logic ent_valid;
  dec_t dec;

  always_comb begin
    dec.word = instr_word;
    dec.pc   = fetch_pc;
    dec.op   = OP_BAD;
    dec.wreg = instr_word[20:16];
    case (instr_word[31:26])
      PRI_SPECIAL: begin
        dec.wreg = instr_word[15:11];
        case (instr_word[5:0])
          FN_SLL:     dec.op = OP_SLL;
          FN_SRL:     dec.op = OP_SRL;
          FN_SRA:     dec.op = OP_SRA;
          FN_SLLV:    dec.op = OP_SLLV;
          FN_SRLV:    dec.op = OP_SRLV;
          FN_SRAV:    dec.op = OP_SRAV;
          FN_JR:      dec.op = OP_JR;
          FN_JALR:    dec.op = OP_JALR;
          FN_SYSCALL: dec.op = OP_SYSCALL;
          FN_MFHI:    dec.op = OP_MFHI;
          FN_MTHI:    dec.op = OP_MTHI;
          FN_MFLO:    dec.op = OP_MFLO;
          FN_MTLO:    dec.op = OP_MTLO;
          FN_MULT:    dec.op = OP_MULT;
          FN_MULTU:   dec.op = OP_MULTU;
          FN_DIV:     dec.op = OP_DIV;
          FN_DIVU:    dec.op = OP_DIVU;
          FN_ADD:     dec.op = OP_ADD;
          FN_ADDU:    dec.op = OP_ADD;
          FN_SUB:     dec.op = OP_SUB;
          FN_SUBU:    dec.op = OP_SUB;
          FN_AND:     dec.op = OP_AND;
          FN_OR:      dec.op = OP_OR;
          FN_XOR:     dec.op = OP_XOR;
          FN_NOR:     dec.op = OP_NOR;
          FN_SLT:     dec.op = OP_SLT;
          FN_SLTU:    dec.op = OP_SLTU;
          default:    dec.op = OP_BAD;
        endcase
      end
      PRI_REGIMM: begin
        dec.wreg = LINK_REG;
        case (instr_word[20:16])
          RI_BLTZ:   dec.op = OP_BLTZ;
          RI_BGEZ:   dec.op = OP_BGEZ;
          RI_BLTZAL: dec.op = OP_BLTZAL;
          RI_BGEZAL: dec.op = OP_BGEZAL;
          default:   dec.op = OP_BAD;
        endcase
      end
      PRI_J:     dec.op = OP_J;
      PRI_JAL:   begin dec.op = OP_JAL; dec.wreg = LINK_REG; end
      PRI_BEQ:   dec.op = OP_BEQ;
      PRI_BNE:   dec.op = OP_BNE;
      PRI_BLEZ:  dec.op = OP_BLEZ;
      PRI_BGTZ:  dec.op = OP_BGTZ;
      PRI_ADDI:  dec.op = OP_ADDI;
      PRI_ADDIU: dec.op = OP_ADDI;
      PRI_SLTI:  dec.op = OP_SLTI;
      PRI_SLTIU: dec.op = OP_SLTIU;
      PRI_ANDI:  dec.op = OP_ANDI;
      PRI_ORI:   dec.op = OP_ORI;
      PRI_XORI:  dec.op = OP_XORI;
      PRI_LUI:   dec.op = OP_LUI;
      default:   dec.op = OP_BAD;
    endcase
    // An all-zero word is a no-op, not a shift of r0 into r0.
    if (instr_word == 32'd0) begin
      dec.op = OP_NOP;
    end
  end

  assign in_ready  = !ent_valid || push_ready;
  assign push      = ent_valid;
  assign push_data = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (in_ready) begin
      ent_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      ent <= dec;
    end
  end

endmodule

// ===== hdl/mie_queue.sv =====
// ----------------------------------------------------------------------------
// MIPS-I execute unit request queue
// Short FIFO of decoded requests between the front end and the back end.
// ----------------------------------------------------------------------------
module mie_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  mie_pkg::dec_t  push_data,
  output logic           pop_valid,
  input  logic           pop,
  output mie_pkg::dec_t  pop_data
);
  import mie_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  dec_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != (PW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/mie_back.sv =====
// ----------------------------------------------------------------------------
// MIPS-I execute unit back end
// Register file, HI/LO, ALU, multiplier and iterative divider, result register.
// ----------------------------------------------------------------------------
module mie_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop,
  input  mie_pkg::dec_t  pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           wb_enable,
  output logic [4:0]     wb_reg,
  output logic [31:0]    wb_value,
  output logic           redirect,
  output logic [31:0]    target_addr,
  output logic           halt_flag,
  output logic           syscall_flag,
  output logic           bad_opcode,
  output logic [5:0]     muldiv_latency
);
  import mie_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DFIX, S_OUT} state_t;

  localparam logic [5:0]  LAT_SHORT = 6'd6, LAT_MID = 6'd9, LAT_LONG = 6'd13;
  localparam logic [5:0]  LAT_DIV = 6'd36;
  localparam logic [31:0] SMALL_BOUND = 32'h800, MID_BOUND = 32'h100000;

  state_t      state;
  dec_t        cur;
  logic [31:0] gpr [32];
  logic [31:0] gpr_vld;
  logic [31:0] a_raw, b_raw;
  logic [31:0] hi, lo;
  logic [63:0] prod;
  logic [31:0] quo, rem, dvs;
  logic [4:0]  cnt;
  logic        neg_q, neg_r;

  logic [4:0]  rs, rt;
  logic [31:0] a, b, imm_s, imm_z, br_tgt, j_tgt, link;
  logic        wen, redir, halt, sysc, bad;
  logic [31:0] wval, tgt;
  logic [5:0]  lat;
  logic        gpr_we;
  logic [32:0] trial;
  logic [31:0] mag_a, mag_b;

  assign rs     = cur.word[25:21];
  assign rt     = cur.word[20:16];
  assign a      = (rs != 5'd0 && gpr_vld[rs]) ? a_raw : 32'd0;
  assign b      = (rt != 5'd0 && gpr_vld[rt]) ? b_raw : 32'd0;
  assign imm_s  = {{16{cur.word[15]}}, cur.word[15:0]};
  assign imm_z  = {16'd0, cur.word[15:0]};
  assign br_tgt = cur.pc + 32'd4 + {imm_s[29:0], 2'b00};
  assign j_tgt  = {4'd0, cur.word[25:0], 2'b00} + ((cur.pc + 32'd4) & 32'hF000_0000);
  assign link   = cur.pc + 32'd8;
  assign mag_a  = a[31] ? (32'd0 - a) : a;
  assign mag_b  = b[31] ? (32'd0 - b) : b;

  always_comb begin
    wen = 1'b0; redir = 1'b0; halt = 1'b0; sysc = 1'b0; bad = 1'b0;
    wval = 32'd0; tgt = br_tgt; lat = 6'd0;
    case (cur.op)
      OP_SLL:    begin wen = 1'b1; wval = b << cur.word[10:6]; end
      OP_SRL:    begin wen = 1'b1; wval = b >> cur.word[10:6]; end
      OP_SRA:    begin wen = 1'b1; wval = 32'($signed(b) >>> cur.word[10:6]); end
      OP_SLLV:   begin wen = 1'b1; wval = b << a[4:0]; end
      OP_SRLV:   begin wen = 1'b1; wval = b >> a[4:0]; end
      OP_SRAV:   begin wen = 1'b1; wval = 32'($signed(b) >>> a[4:0]); end
      OP_JR:     begin redir = 1'b1; tgt = a; end
      OP_JALR:   begin redir = 1'b1; tgt = a; wen = 1'b1; wval = link; end
      OP_SYSCALL: sysc = 1'b1;
      OP_MFHI:   begin wen = 1'b1; wval = hi; end
      OP_MFLO:   begin wen = 1'b1; wval = lo; end
      OP_MULT: begin
        if (!a[31]) begin
          lat = (a < SMALL_BOUND) ? LAT_SHORT : ((a < MID_BOUND) ? LAT_MID : LAT_LONG);
        end else begin
          lat = ($signed(a) >= -$signed(SMALL_BOUND)) ? LAT_SHORT :
                (($signed(a) >= -$signed(MID_BOUND)) ? LAT_MID : LAT_LONG);
        end
      end
      OP_MULTU:
        lat = (a < SMALL_BOUND) ? LAT_SHORT : ((a < MID_BOUND) ? LAT_MID : LAT_LONG);
      OP_DIV, OP_DIVU: lat = LAT_DIV;
      OP_ADD:    begin wen = 1'b1; wval = a + b; end
      OP_SUB:    begin wen = 1'b1; wval = a - b; end
      OP_AND:    begin wen = 1'b1; wval = a & b; end
      OP_OR:     begin wen = 1'b1; wval = a | b; end
      OP_XOR:    begin wen = 1'b1; wval = a ^ b; end
      OP_NOR:    begin wen = 1'b1; wval = ~(a | b); end
      OP_SLT:    begin wen = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
      OP_SLTU:   begin wen = 1'b1; wval = {31'd0, a < b}; end
      OP_BLTZ:   redir = a[31];
      OP_BGEZ:   redir = !a[31];
      OP_BLTZAL: begin redir = a[31]; wen = 1'b1; wval = link; end
      OP_BGEZAL: begin redir = !a[31]; wen = 1'b1; wval = link; end
      OP_J:      begin redir = 1'b1; tgt = j_tgt; halt = (j_tgt == cur.pc); end
      OP_JAL:    begin redir = 1'b1; tgt = j_tgt; wen = 1'b1; wval = link; end
      OP_BEQ:    redir = (a == b);
      OP_BNE:    redir = (a != b);
      OP_BLEZ:   redir = a[31] || (a == 32'd0);
      OP_BGTZ:   redir = !a[31] && (a != 32'd0);
      OP_ADDI:   begin wen = 1'b1; wval = a + imm_s; end
      OP_SLTI:   begin wen = 1'b1; wval = {31'd0, $signed(a) < $signed(imm_s)}; end
      OP_SLTIU:  begin wen = 1'b1; wval = {31'd0, a < imm_s}; end
      OP_ANDI:   begin wen = 1'b1; wval = a & imm_z; end
      OP_ORI:    begin wen = 1'b1; wval = a | imm_z; end
      OP_XORI:   begin wen = 1'b1; wval = a ^ imm_z; end
      OP_LUI:    begin wen = 1'b1; wval = {cur.word[15:0], 16'd0}; end
      OP_BAD:    bad = 1'b1;
      default:   wen = 1'b0;
    endcase
    // A write to r0 is dropped entirely.
    if (cur.wreg == 5'd0) begin
      wen = 1'b0;
    end
    if (!wen) begin
      wval = 32'd0;
    end
    if (!redir) begin
      tgt = 32'd0;
    end
  end

  assign gpr_we = (state == S_EXEC) && wen;
  assign pop    = (state == S_IDLE) && pop_valid;
  assign trial  = {rem, quo[31]} - {1'b0, dvs};
  assign out_valid = (state == S_OUT);

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (gpr_we) begin
      gpr[cur.wreg] <= wval;
    end
    if (pop) begin
      a_raw <= gpr[pop_data.word[25:21]];
      b_raw <= gpr[pop_data.word[20:16]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      gpr_vld <= '0;
      hi      <= '0;
      lo      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cur   <= pop_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (gpr_we) begin
            gpr_vld[cur.wreg] <= 1'b1;
          end
          wb_enable      <= wen;
          wb_reg         <= wen ? cur.wreg : 5'd0;
          wb_value       <= wval;
          redirect       <= redir;
          target_addr    <= tgt;
          halt_flag      <= halt;
          syscall_flag   <= sysc;
          bad_opcode     <= bad;
          muldiv_latency <= lat;
          state          <= S_OUT;
          case (cur.op)
            OP_MTHI: hi <= a;
            OP_MTLO: lo <= a;
            OP_MULT: begin
              prod  <= 64'($signed({a[31], a}) * $signed({b[31], b}));
              state <= S_MUL;
            end
            OP_MULTU: begin
              prod  <= a * b;
              state <= S_MUL;
            end
            OP_DIV, OP_DIVU: begin
              if (b == 32'd0) begin
                hi <= a;
                lo <= (cur.op == OP_DIV && a[31]) ? 32'd1 : 32'hFFFF_FFFF;
              end else begin
                quo   <= (cur.op == OP_DIV) ? mag_a : a;
                dvs   <= (cur.op == OP_DIV) ? mag_b : b;
                neg_q <= (cur.op == OP_DIV) && (a[31] ^ b[31]);
                neg_r <= (cur.op == OP_DIV) && a[31];
                rem   <= 32'd0;
                cnt   <= 5'd0;
                state <= S_DIV;
              end
            end
            default: hi <= hi;
          endcase
        end
        S_MUL: begin
          hi    <= prod[63:32];
          lo    <= prod[31:0];
          state <= S_OUT;
        end
        S_DIV: begin
          // One restoring step per cycle, quotient bit shifted in at the bottom.
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_DFIX;
          end
        end
        S_DFIX: begin
          lo    <= neg_q ? (32'd0 - quo) : quo;
          hi    <= neg_r ? (32'd0 - rem) : rem;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/mips1_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// MIPS-I integer execute unit
// Executes one MIPS-I instruction per request and reports its one result.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   in       in_valid / in_ready  instr_word, fetch_pc
//   out      out_valid/out_ready  wb_enable .. muldiv_latency
//
// The front end classifies a request and registers it, and can take a new
// one every cycle while the two-entry queue has room.
// The back end takes an ordinary instruction through register read, execute
// and result hold; mult/multu add a HI/LO step, and div/divu by a nonzero
// divisor run the radix-2 divider, one quotient bit per cycle, and a sign fix.
// Reset is synchronous; the register file reads as zero until each entry is
// first written, tracked by one valid flop per register, so no clearing pass.
// A stalled output holds the back end only; the front keeps filling the queue.
//
`include "mips1_integer_execute_unit_macros.svh"

module mips1_integer_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  input  logic [31:0] fetch_pc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        wb_enable,
  output logic [4:0]  wb_reg,
  output logic [31:0] wb_value,
  output logic        redirect,
  output logic [31:0] target_addr,
  output logic        halt_flag,
  output logic        syscall_flag,
  output logic        bad_opcode,
  output logic [5:0]  muldiv_latency
);
  import mie_pkg::*;

  logic push, push_ready, pop_valid, pop;
  dec_t push_data, pop_data;

  // Front end: request register and decode.
  mie_front u_front (
    .clk, .rst, .in_valid, .in_ready, .instr_word, .fetch_pc,
    .push, .push_ready, .push_data
  );

  // Decoupling queue so the front and back stall independently.
  mie_queue u_queue (
    .clk, .rst, .push, .push_ready, .push_data, .pop_valid, .pop, .pop_data
  );

  // Back end: execution, architectural state and result register.
  mie_back u_back (
    .clk, .rst, .pop_valid, .pop, .pop_data, .out_valid, .out_ready,
    .wb_enable, .wb_reg, .wb_value, .redirect, .target_addr, .halt_flag,
    .syscall_flag, .bad_opcode, .muldiv_latency
  );

  // A halt is always a taken jump.
  `MIE_ASSERT_NOW(a_halt_redirect, out_valid && halt_flag, redirect, "halt without redirect")
  // Unknown opcodes have no other effect.
  `MIE_ASSERT_NOW(a_bad_quiet, out_valid && bad_opcode, !wb_enable && !redirect && muldiv_latency == 6'd0, "bad opcode with side effect")
  // Multiply/divide never writes a general register.
  `MIE_ASSERT_NOW(a_muldiv_nowb, out_valid && muldiv_latency != 6'd0, !wb_enable && !redirect, "muldiv with writeback")

endmodule

// ===== test/mips1_integer_execute_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS-I execute unit result checker
// Watches both channels, runs its own model of the register file and HI/LO
// on every accepted request, and compares each result field by field.
// ----------------------------------------------------------------------------
module mips1_integer_execute_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] instr_word,
  input  logic [31:0] fetch_pc,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        wb_enable,
  input  logic [4:0]  wb_reg,
  input  logic [31:0] wb_value,
  input  logic        redirect,
  input  logic [31:0] target_addr,
  input  logic        halt_flag,
  input  logic        syscall_flag,
  input  logic        bad_opcode,
  input  logic [5:0]  muldiv_latency,
  output int          mismatch_count,
  output int          pending_count
);

  typedef struct packed {
    logic        wen;
    logic [4:0]  wreg;
    logic [31:0] wval;
    logic        redir;
    logic [31:0] tgt;
    logic        halt;
    logic        sysc;
    logic        bad;
    logic [5:0]  lat;
  } exec_result_t;

  localparam logic [5:0] PRI_SPECIAL = 6'h00, PRI_REGIMM = 6'h01, PRI_J = 6'h02,
    PRI_JAL = 6'h03, PRI_BEQ = 6'h04, PRI_BNE = 6'h05, PRI_BLEZ = 6'h06,
    PRI_BGTZ = 6'h07, PRI_ADDI = 6'h08, PRI_ADDIU = 6'h09, PRI_SLTI = 6'h0A,
    PRI_SLTIU = 6'h0B, PRI_ANDI = 6'h0C, PRI_ORI = 6'h0D, PRI_XORI = 6'h0E,
    PRI_LUI = 6'h0F;
  localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03,
    FN_SLLV = 6'h04, FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08,
    FN_JALR = 6'h09, FN_SYSCALL = 6'h0C, FN_MFHI = 6'h10, FN_MTHI = 6'h11,
    FN_MFLO = 6'h12, FN_MTLO = 6'h13, FN_MULT = 6'h18, FN_MULTU = 6'h19,
    FN_DIV = 6'h1A, FN_DIVU = 6'h1B, FN_ADD = 6'h20, FN_ADDU = 6'h21,
    FN_SUB = 6'h22, FN_SUBU = 6'h23, FN_AND = 6'h24, FN_OR = 6'h25,
    FN_XOR = 6'h26, FN_NOR = 6'h27, FN_SLT = 6'h2A, FN_SLTU = 6'h2B;
  localparam logic [4:0] RI_BLTZ = 5'h00, RI_BGEZ = 5'h01, RI_BLTZAL = 5'h10,
    RI_BGEZAL = 5'h11;

  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q;
  exec_result_t expected_results [$];

  function automatic logic [5:0] mult_latency(logic signed [31:0] v);
    if (v >= 0) return v < 32'sh800 ? 6'd6 : (v < 32'sh100000 ? 6'd9 : 6'd13);
    return v >= -32'sh800 ? 6'd6 : (v >= -32'sh100000 ? 6'd9 : 6'd13);
  endfunction

  // Executes one instruction against the model state and returns its result.
  function automatic exec_result_t execute(logic [31:0] w, logic [31:0] pc);
    exec_result_t r;
    logic [31:0] a, b, imm_s, imm_z, br;
    logic [63:0] p;
    logic [4:0] sa;
    r = '0;
    a = gpr[w[25:21]];
    b = gpr[w[20:16]];
    sa = w[10:6];
    imm_s = {{16{w[15]}}, w[15:0]};
    imm_z = {16'h0, w[15:0]};
    br = pc + 32'd4 + (imm_s << 2);
    if (w != 0) begin
      case (w[31:26])
        PRI_SPECIAL: begin
          r.wreg = w[15:11];
          r.wen = 1'b1;
          case (w[5:0])
            FN_SLL:  r.wval = b << sa;
            FN_SRL:  r.wval = b >> sa;
            FN_SRA:  r.wval = $signed(b) >>> sa;
            FN_SLLV: r.wval = b << a[4:0];
            FN_SRLV: r.wval = b >> a[4:0];
            FN_SRAV: r.wval = $signed(b) >>> a[4:0];
            FN_JR: begin
              r.wen = 1'b0; r.redir = 1'b1; r.tgt = a;
            end
            FN_JALR: begin
              r.redir = 1'b1; r.tgt = a; r.wval = pc + 32'd8;
            end
            FN_SYSCALL: begin
              r.wen = 1'b0; r.sysc = 1'b1;
            end
            FN_MFHI: r.wval = hi_q;
            FN_MFLO: r.wval = lo_q;
            FN_MTHI: begin
              r.wen = 1'b0; hi_q = a;
            end
            FN_MTLO: begin
              r.wen = 1'b0; lo_q = a;
            end
            FN_MULT: begin
              r.wen = 1'b0;
              p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              {hi_q, lo_q} = p;
              r.lat = mult_latency(a);
            end
            FN_MULTU: begin
              r.wen = 1'b0;
              p = {32'h0, a} * {32'h0, b};
              {hi_q, lo_q} = p;
              r.lat = a < 32'h800 ? 6'd6 : (a < 32'h100000 ? 6'd9 : 6'd13);
            end
            FN_DIV: begin
              r.wen = 1'b0; r.lat = 6'd36;
              if (b == 0) begin
                hi_q = a; lo_q = a[31] ? 32'd1 : 32'hFFFFFFFF;
              end else if (a == 32'h80000000 && b == 32'hFFFFFFFF) begin
                lo_q = 32'h80000000; hi_q = 32'h0;
              end else begin
                lo_q = $signed(a) / $signed(b);
                hi_q = $signed(a) % $signed(b);
              end
            end
            FN_DIVU: begin
              r.wen = 1'b0; r.lat = 6'd36;
              if (b == 0) begin
                hi_q = a; lo_q = 32'hFFFFFFFF;
              end else begin
                lo_q = a / b; hi_q = a % b;
              end
            end
            FN_ADD, FN_ADDU: r.wval = a + b;
            FN_SUB, FN_SUBU: r.wval = a - b;
            FN_AND: r.wval = a & b;
            FN_OR:  r.wval = a | b;
            FN_XOR: r.wval = a ^ b;
            FN_NOR: r.wval = ~(a | b);
            FN_SLT: r.wval = {31'h0, $signed(a) < $signed(b)};
            FN_SLTU: r.wval = {31'h0, a < b};
            default: begin
              r.wen = 1'b0; r.bad = 1'b1;
            end
          endcase
        end
        PRI_REGIMM: begin
          case (w[20:16])
            RI_BLTZ: r.redir = a[31];
            RI_BGEZ: r.redir = !a[31];
            RI_BLTZAL, RI_BGEZAL: begin
              // The link is written whether or not the branch is taken.
              r.redir = w[16] ? !a[31] : a[31];
              r.wen = 1'b1; r.wreg = 5'd31; r.wval = pc + 32'd8;
            end
            default: r.bad = 1'b1;
          endcase
          r.tgt = br;
        end
        PRI_J, PRI_JAL: begin
          r.redir = 1'b1;
          r.tgt = {4'h0, w[25:0], 2'b00} + ((pc + 32'd4) & 32'hF0000000);
          if (w[26]) begin
            r.wen = 1'b1; r.wreg = 5'd31; r.wval = pc + 32'd8;
          end else begin
            r.halt = (r.tgt == pc);
          end
        end
        PRI_BEQ:  begin r.redir = a == b; r.tgt = br; end
        PRI_BNE:  begin r.redir = a != b; r.tgt = br; end
        PRI_BLEZ: begin r.redir = a[31] || a == 0; r.tgt = br; end
        PRI_BGTZ: begin r.redir = !a[31] && a != 0; r.tgt = br; end
        PRI_ADDI, PRI_ADDIU: begin r.wen = 1'b1; r.wreg = w[20:16]; r.wval = a + imm_s; end
        PRI_SLTI: begin
          r.wen = 1'b1; r.wreg = w[20:16]; r.wval = {31'h0, $signed(a) < $signed(imm_s)};
        end
        PRI_SLTIU: begin r.wen = 1'b1; r.wreg = w[20:16]; r.wval = {31'h0, a < imm_s}; end
        PRI_ANDI: begin r.wen = 1'b1; r.wreg = w[20:16]; r.wval = a & imm_z; end
        PRI_ORI:  begin r.wen = 1'b1; r.wreg = w[20:16]; r.wval = a | imm_z; end
        PRI_XORI: begin r.wen = 1'b1; r.wreg = w[20:16]; r.wval = a ^ imm_z; end
        PRI_LUI:  begin r.wen = 1'b1; r.wreg = w[20:16]; r.wval = imm_z << 16; end
        default: r.bad = 1'b1;
      endcase
    end
    if (r.wen && r.wreg != 0) gpr[r.wreg] = r.wval;
    else begin
      r.wen = 1'b0; r.wreg = '0; r.wval = '0;
    end
    if (!r.redir) r.tgt = '0;
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    exec_result_t got, want;
    if (rst) begin
      foreach (gpr[i]) gpr[i] = '0;
      hi_q = '0;
      lo_q = '0;
      expected_results.delete();
      mismatch_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{wb_enable, wb_reg, wb_value, redirect, target_addr, halt_flag,
                syscall_flag, bad_opcode, muldiv_latency};
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) $display("Unexpected result %h", got);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("Result mismatch: expected %h, got %h", want, got);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(execute(instr_word, fetch_pc));
    end
  end

endmodule

// ===== test/mips1_integer_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS-I execute unit testbench
// Drives directed and random instruction streams with random stalls on both
// sides; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module mips1_integer_execute_unit_tb;

  localparam int RANDOM_REQUESTS = 950;
  localparam int HOLD_OFF_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instr_word = '0;
  logic [31:0] fetch_pc = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        wb_enable, redirect, halt_flag, syscall_flag, bad_opcode;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value, target_addr;
  logic [5:0]  muldiv_latency;
  int          mismatch_count, pending_count;
  bit          calm = 1'b0;   // no random idling while set
  bit          hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mips1_integer_execute_unit uut (.*);

  mips1_integer_execute_unit_checker checker_i (.*);

  // Receiver: random back-pressure, plus one long hold-off while requests keep coming.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && (calm || $urandom_range(99) >= 27);
  end

  initial begin
    repeat (150) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Offers one request, holds it until accepted, then may idle at random with in_valid low.
  task automatic send_request(logic [31:0] w, logic [31:0] pc);
    in_valid <= 1'b1;
    instr_word <= w;
    fetch_pc <= pc;
    do @(posedge clk); while (!in_ready);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] r_type(logic [4:0] rs, rt, rd, sa, logic [5:0] fn);
    return {6'h00, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Random instruction biased toward executed opcodes and a few registers.
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    logic [5:0] fns [27] = '{6'h00, 6'h02, 6'h03, 6'h04, 6'h06, 6'h07, 6'h08,
      6'h09, 6'h0C, 6'h10, 6'h11, 6'h12, 6'h13, 6'h18, 6'h19, 6'h1A, 6'h1B,
      6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27, 6'h2A, 6'h2B};
    w = $urandom;
    if ($urandom_range(9) < 3) w[25:16] = {2'b0, w[23:21], 2'b0, w[18:16]};
    case ($urandom_range(9))
      0, 1, 2, 3: w[31:26] = 6'h00;
      4, 5, 6:    w[31:26] = 6'h08 + 6'($urandom_range(7));
      7:          w[31:26] = 6'($urandom_range(7));
      default: ;
    endcase
    if (w[31:26] == 6'h00 && $urandom_range(9) != 0) w[5:0] = fns[$urandom_range(26)];
    if (w[31:26] == 6'h01 && $urandom_range(3) != 0) w[20:16] = {w[20], 3'b0, w[16]};
    return w;
  endfunction

  initial begin
    logic [31:0] pc;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, division corners, link cases, halt, syscall, bad codes.
    send_request(32'h0, 32'h0);
    send_request(i_type(6'h0F, 5'd0, 5'd1, 16'h8000), 32'h4);      // r1 = 0x80000000
    send_request(i_type(6'h09, 5'd0, 5'd2, 16'hFFFF), 32'h8);      // r2 = -1
    send_request(i_type(6'h0D, 5'd0, 5'd3, 16'hFFFF), 32'hC);
    send_request(i_type(6'h08, 5'd0, 5'd0, 16'h1234), 32'h10);     // write to r0
    send_request(r_type(5'd1, 5'd2, 5'd0, 5'd0, 6'h1A), 32'h14);   // overflow divide
    send_request(r_type(5'd0, 5'd0, 5'd4, 5'd0, 6'h12), 32'h18);
    send_request(r_type(5'd1, 5'd0, 5'd0, 5'd0, 6'h1A), 32'h1C);   // div by zero, negative
    send_request(r_type(5'd0, 5'd0, 5'd5, 5'd0, 6'h12), 32'h20);
    send_request(r_type(5'd3, 5'd0, 5'd0, 5'd0, 6'h1A), 32'h24);   // div by zero, positive
    send_request(r_type(5'd1, 5'd0, 5'd0, 5'd0, 6'h1B), 32'h28);
    send_request(r_type(5'd1, 5'd2, 5'd0, 5'd0, 6'h18), 32'h2C);
    send_request(r_type(5'd2, 5'd1, 5'd0, 5'd0, 6'h19), 32'h30);
    send_request(r_type(5'd0, 5'd0, 5'd6, 5'd0, 6'h10), 32'h34);
    send_request(r_type(5'd0, 5'd1, 5'd7, 5'd31, 6'h03), 32'h38);
    send_request({6'h01, 5'd3, 5'h10, 16'h0004}, 32'hFFFFFFF0);    // bltzal not taken
    send_request({6'h01, 5'd31, 5'h11, 16'h8000}, 32'h40);         // link equals source
    send_request(r_type(5'd31, 5'd0, 5'd31, 5'd0, 6'h09), 32'h44); // jalr with rd == rs
    send_request({6'h02, 26'h0000012}, 32'h48);                    // jump to itself
    send_request({6'h03, 26'h3FFFFFF}, 32'hEFFFFFFC);
    send_request(r_type(5'd0, 5'd0, 5'd0, 5'd0, 6'h0C), 32'h50);
    send_request(r_type(5'd0, 5'd0, 5'd0, 5'd0, 6'h3F), 32'h54);
    send_request({6'h23, 26'h0}, 32'h58);
    send_request({6'h01, 5'd0, 5'h1F, 16'h0}, 32'h5C);
    send_request(i_type(6'h07, 5'd3, 5'd0, 16'h7FFF), 32'h60);
    // Random: first part without idling, then with.
    pc = $urandom;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      calm = (i < 120);
      pc = ($urandom_range(3) == 0) ? $urandom : pc + 32'd4;
      send_request(random_instr(), pc);
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    // Let the checker record the last accepted request before draining.
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
